// File: sv/vgat_pkg.sv
// Shared types, constants and helper functions of the VGA timing block.
package vgat_pkg;

  localparam int unsigned PIX_W          = 12;
  localparam int unsigned DUR_W          = 16;
  localparam int unsigned GEOM_W         = 12;
  localparam int unsigned LINE_W         = 11;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned FIFO_DEPTH_DEF = 64;

  localparam logic [GEOM_W-1:0] GEOM_MAX = 12'd2048;
  localparam logic [PIX_W-1:0]  PIX_MASK = 12'hFFF;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam logic [DUR_W-1:0]  RST_VSYNC  = 16'd2;
  localparam logic [DUR_W-1:0]  RST_VBACK  = 16'd33;
  localparam logic [DUR_W-1:0]  RST_VFRONT = 16'd10;
  localparam logic [DUR_W-1:0]  RST_HSYNC  = 16'd96;
  localparam logic [DUR_W-1:0]  RST_HBACK  = 16'd48;
  localparam logic [DUR_W-1:0]  RST_HFRONT = 16'd16;
  localparam logic [GEOM_W-1:0] RST_COLS   = 12'd640;
  localparam logic [GEOM_W-1:0] RST_ROWS   = 12'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VSYNC  = 3'd0,
    CFG_VBACK  = 3'd1,
    CFG_VFRONT = 3'd2,
    CFG_HSYNC  = 3'd3,
    CFG_HBACK  = 3'd4,
    CFG_HFRONT = 3'd5,
    CFG_COLS   = 3'd6,
    CFG_ROWS   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic             func;
    logic [PIX_W-1:0] wr_pixel;
  } in_t;

  typedef struct packed {
    logic             hsync_n;
    logic             vsync_n;
    logic             pixel_strobe;
    logic [PIX_W-1:0] pixel_value;
  } out_t;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [PIX_W-1:0] pixel;
  } fifo_req_t;

  typedef struct packed {
    logic             empty;
    logic [PIX_W-1:0] head;
  } fifo_stat_t;

  function automatic logic [DUR_W-1:0] at_least_one(input logic [DUR_W-1:0] v);
    return (v == '0) ? DUR_W'(1) : v;
  endfunction

  function automatic logic [GEOM_W-1:0] geom(input logic [GEOM_W-1:0] v);
    logic [GEOM_W-1:0] r;
    if (v == '0) begin
      r = GEOM_W'(1);
    end else if (v > GEOM_MAX) begin
      r = GEOM_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: sv/vga_timing_with_pixel_fifo.sv
// VGA timing generator fed by a pixel FIFO: handshake and result registers.
// A tick item passes the input register, then the result register, on its way to out_valid.
// Throughput: one item per cycle unless out_ready stalls a tick; a write item does not wait on it.
// Backpressure on out_ready stalls tick items in the input register only.
// Reset: rst_n synchronous, active low; clears sequencer, pointers, counts and valid flags.
// The pixel RAM is not cleared: only entries holding a pushed pixel are ever used.
module vga_timing_with_pixel_fifo #(
  parameter int unsigned FIFO_DEPTH = vgat_pkg::FIFO_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  vgat_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output vgat_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  vgat_pkg::cfg_idx_t              cfg_index,
  input  logic [vgat_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                 in_valid_r;
  vgat_pkg::in_t        in_data_r;
  logic                 out_valid_r;
  vgat_pkg::out_t       out_data_r;
  logic                 out_free, is_write, advance;
  vgat_pkg::fifo_req_t  fifo_req;
  vgat_pkg::fifo_stat_t fifo_stat;
  vgat_pkg::out_t       res;

  assign out_free = !out_valid_r || out_ready;
  assign is_write = (in_data_r.func == vgat_pkg::FUNC_WRITE);
  assign advance  = in_valid_r && (is_write || out_free);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= advance && !is_write;
      end
    end
    if (in_ready) begin
      in_data_r <= in_data;
    end
    if (out_free) begin
      out_data_r <= res;
    end
  end

  vgat_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .go        (advance),
    .item      (in_data_r),
    .stat      (fifo_stat),
    .req       (fifo_req),
    .res       (res)
  );

  vgat_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fifo_req),
    .stat  (fifo_stat)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |-> (out_valid_r && !out_ready && !is_write))
    else $error("input stage stalled without output backpressure");

  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !is_write) |=> out_valid_r)
    else $error("tick item produced no result");

endmodule

// File: sv/vgat_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module vgat_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/vgat_fifo.sv
// Pixel FIFO: pointers, fill count, RAM and write-to-head bypass.
module vgat_fifo #(
  parameter int unsigned DEPTH = vgat_pkg::FIFO_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vgat_pkg::fifo_req_t  req,
  output vgat_pkg::fifo_stat_t stat
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          byp_sel_r, byp_sel_nxt;
  logic [vgat_pkg::PIX_W-1:0] byp_data_r;
  logic [vgat_pkg::PIX_W-1:0] ram_rd_data;
  logic          full, empty, do_push, do_pop;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = req.push && !full;
  assign do_pop  = req.pop && !empty;

  always_comb begin
    head_nxt    = do_pop ? ptr_inc(head_r) : head_r;
    tail_nxt    = do_push ? ptr_inc(tail_r) : tail_r;
    cnt_nxt     = cnt_r + CW'(do_push) - CW'(do_pop);
    byp_sel_nxt = do_push && (tail_r == head_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      cnt_r     <= '0;
      byp_sel_r <= 1'b0;
    end else begin
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      cnt_r     <= cnt_nxt;
      byp_sel_r <= byp_sel_nxt;
    end
    byp_data_r <= req.pixel;
  end

  vgat_ram #(
    .WIDTH (vgat_pkg::PIX_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (do_push),
    .wr_addr (tail_r),
    .wr_data (req.pixel),
    .rd_addr (head_nxt),
    .rd_data (ram_rd_data)
  );

  assign stat.empty = empty;
  assign stat.head  = byp_sel_r ? byp_data_r : ram_rd_data;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("fifo count above depth");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    do_push |=> !empty)
    else $error("fifo empty after accepted push");

endmodule

// File: sv/vgat_seq.sv
// Sync phase sequencer with its configuration registers.
module vgat_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  vgat_pkg::cfg_idx_t   cfg_index,
  input  logic [vgat_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                 go,
  input  vgat_pkg::in_t        item,
  input  vgat_pkg::fifo_stat_t stat,
  output vgat_pkg::fifo_req_t  req,
  output vgat_pkg::out_t       res
);

  typedef enum logic [2:0] {
    PH_VSYNC  = 3'd0,
    PH_VBACK  = 3'd1,
    PH_HSYNC  = 3'd2,
    PH_HBACK  = 3'd3,
    PH_ACTIVE = 3'd4,
    PH_HFRONT = 3'd5,
    PH_VFRONT = 3'd6
  } phase_t;

  logic [vgat_pkg::DUR_W-1:0]  vsync_r, vback_r, vfront_r, hsync_r, hback_r, hfront_r;
  logic [vgat_pkg::GEOM_W-1:0] cols_r, rows_r;

  phase_t phase_r, phase_nxt, ph_cur;
  logic [vgat_pkg::DUR_W-1:0]  left_r, left_nxt, len_sel, left_cur;
  logic [vgat_pkg::LINE_W-1:0] line_r, line_nxt, line_cur;
  logic [vgat_pkg::GEOM_W-1:0] line_inc;
  logic hs_r, hs_nxt, vs_r, vs_nxt;
  logic tick, enter, active, pop;

  assign tick   = go && (item.func == vgat_pkg::FUNC_TICK);
  assign ph_cur = (phase_r > PH_VFRONT) ? PH_VSYNC : phase_r;
  assign enter  = (left_r == '0);
  assign active = (ph_cur == PH_ACTIVE);
  assign pop    = tick && active && !stat.empty;

  always_comb begin
    unique case (ph_cur)
      PH_VSYNC:  len_sel = vgat_pkg::at_least_one(vsync_r);
      PH_VBACK:  len_sel = vgat_pkg::at_least_one(vback_r);
      PH_HSYNC:  len_sel = vgat_pkg::at_least_one(hsync_r);
      PH_HBACK:  len_sel = vgat_pkg::at_least_one(hback_r);
      PH_ACTIVE: len_sel = vgat_pkg::DUR_W'(vgat_pkg::geom(cols_r));
      PH_HFRONT: len_sel = vgat_pkg::at_least_one(hfront_r);
      default:   len_sel = vgat_pkg::at_least_one(vfront_r);
    endcase

    left_cur = enter ? len_sel : left_r;
    line_cur = (enter && (ph_cur == PH_VSYNC)) ? '0 : line_r;
    line_inc = {1'b0, line_cur} + vgat_pkg::GEOM_W'(1);

    hs_nxt = hs_r;
    vs_nxt = vs_r;
    unique case (ph_cur)
      PH_VSYNC: begin
        vs_nxt = 1'b0;
        hs_nxt = 1'b1;
      end
      PH_VBACK, PH_VFRONT: vs_nxt = 1'b1;
      PH_HSYNC: hs_nxt = 1'b0;
      default:  hs_nxt = 1'b1;
    endcase

    left_nxt  = left_cur - vgat_pkg::DUR_W'(1);
    phase_nxt = ph_cur;
    line_nxt  = line_cur;
    if (left_nxt == '0) begin
      unique case (ph_cur)
        PH_VSYNC:  phase_nxt = PH_VBACK;
        PH_VBACK:  phase_nxt = PH_HSYNC;
        PH_HSYNC:  phase_nxt = PH_HBACK;
        PH_HBACK:  phase_nxt = PH_ACTIVE;
        PH_ACTIVE: phase_nxt = PH_HFRONT;
        PH_HFRONT: begin
          phase_nxt = (line_inc >= vgat_pkg::geom(rows_r)) ? PH_VFRONT : PH_HSYNC;
          line_nxt  = line_inc[vgat_pkg::LINE_W-1:0];
        end
        default:   phase_nxt = PH_VSYNC;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_VSYNC;
      left_r   <= '0;
      line_r   <= '0;
      hs_r     <= 1'b1;
      vs_r     <= 1'b1;
      vsync_r  <= vgat_pkg::RST_VSYNC;
      vback_r  <= vgat_pkg::RST_VBACK;
      vfront_r <= vgat_pkg::RST_VFRONT;
      hsync_r  <= vgat_pkg::RST_HSYNC;
      hback_r  <= vgat_pkg::RST_HBACK;
      hfront_r <= vgat_pkg::RST_HFRONT;
      cols_r   <= vgat_pkg::RST_COLS;
      rows_r   <= vgat_pkg::RST_ROWS;
    end else begin
      if (tick) begin
        phase_r <= phase_nxt;
        left_r  <= left_nxt;
        line_r  <= line_nxt;
        hs_r    <= hs_nxt;
        vs_r    <= vs_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          vgat_pkg::CFG_VSYNC:  vsync_r  <= cfg_data;
          vgat_pkg::CFG_VBACK:  vback_r  <= cfg_data;
          vgat_pkg::CFG_VFRONT: vfront_r <= cfg_data;
          vgat_pkg::CFG_HSYNC:  hsync_r  <= cfg_data;
          vgat_pkg::CFG_HBACK:  hback_r  <= cfg_data;
          vgat_pkg::CFG_HFRONT: hfront_r <= cfg_data;
          vgat_pkg::CFG_COLS:   cols_r   <= cfg_data[vgat_pkg::GEOM_W-1:0];
          vgat_pkg::CFG_ROWS:   rows_r   <= cfg_data[vgat_pkg::GEOM_W-1:0];
        endcase
      end
    end
  end

  assign req.push  = go && (item.func == vgat_pkg::FUNC_WRITE);
  assign req.pop   = pop;
  assign req.pixel = item.wr_pixel & vgat_pkg::PIX_MASK;

  assign res.hsync_n      = hs_nxt;
  assign res.vsync_n      = vs_nxt;
  assign res.pixel_strobe = active;
  assign res.pixel_value  = pop ? stat.head : '0;

  a_vsync_low: assert property (@(posedge clk) disable iff (!rst_n)
    (tick && (ph_cur == PH_VSYNC)) |=> !vs_r && hs_r)
    else $error("vsync phase did not drive sync levels");

  a_blank_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !res.pixel_strobe |-> (res.pixel_value == '0) && !req.pop)
    else $error("pixel sent outside active phase");

endmodule

// File: bench/vga_timing_with_pixel_fifo_test.sv
// Self-checking bench for the VGA timing block: sync, strobe and pixel checks under random flow.
module vga_timing_with_pixel_fifo_test;

  typedef enum logic [2:0] {
    SEQ_VSYNC,
    SEQ_VBACK,
    SEQ_HSYNC,
    SEQ_HBACK,
    SEQ_ACTIVE,
    SEQ_HFRONT,
    SEQ_VFRONT
  } seq_phase_t;

  class frame_scoreboard;
    logic [vgat_pkg::DUR_W-1:0] regs [8];
    seq_phase_t                 seq;
    int unsigned                ticks_left;
    int unsigned                line_no;
    logic                       hs_level;
    logic                       vs_level;
    logic [vgat_pkg::PIX_W-1:0] pixel_q [$];
    vgat_pkg::out_t             expected_q [$];
    int unsigned                errors;
    int unsigned                n_items;
    int unsigned                n_writes;
    int unsigned                n_dropped;
    int unsigned                n_results;

    function new();
      regs[vgat_pkg::CFG_VSYNC]  = vgat_pkg::RST_VSYNC;
      regs[vgat_pkg::CFG_VBACK]  = vgat_pkg::RST_VBACK;
      regs[vgat_pkg::CFG_VFRONT] = vgat_pkg::RST_VFRONT;
      regs[vgat_pkg::CFG_HSYNC]  = vgat_pkg::RST_HSYNC;
      regs[vgat_pkg::CFG_HBACK]  = vgat_pkg::RST_HBACK;
      regs[vgat_pkg::CFG_HFRONT] = vgat_pkg::RST_HFRONT;
      regs[vgat_pkg::CFG_COLS]   = vgat_pkg::DUR_W'(vgat_pkg::RST_COLS);
      regs[vgat_pkg::CFG_ROWS]   = vgat_pkg::DUR_W'(vgat_pkg::RST_ROWS);
      seq        = SEQ_VSYNC;
      ticks_left = 0;
      line_no    = 0;
      hs_level   = 1'b1;
      vs_level   = 1'b1;
      errors     = 0;
      n_items    = 0;
      n_writes   = 0;
      n_dropped  = 0;
      n_results  = 0;
    endfunction

    function void write_reg(vgat_pkg::cfg_idx_t idx, logic [vgat_pkg::DUR_W-1:0] v);
      if (idx == vgat_pkg::CFG_COLS || idx == vgat_pkg::CFG_ROWS) begin
        regs[idx] = vgat_pkg::DUR_W'(v[vgat_pkg::GEOM_W-1:0]);
      end else begin
        regs[idx] = v;
      end
    endfunction

    function int unsigned min_one(logic [vgat_pkg::DUR_W-1:0] v);
      return (v == '0) ? 1 : 32'(v);
    endfunction

    function int unsigned clamp_geometry(logic [vgat_pkg::DUR_W-1:0] v);
      if (v == '0) return 1;
      if (v > vgat_pkg::GEOM_MAX) return 32'(vgat_pkg::GEOM_MAX);
      return 32'(v);
    endfunction

    function int unsigned phase_ticks();
      case (seq)
        SEQ_VSYNC:  return min_one(regs[vgat_pkg::CFG_VSYNC]);
        SEQ_VBACK:  return min_one(regs[vgat_pkg::CFG_VBACK]);
        SEQ_HSYNC:  return min_one(regs[vgat_pkg::CFG_HSYNC]);
        SEQ_HBACK:  return min_one(regs[vgat_pkg::CFG_HBACK]);
        SEQ_ACTIVE: return clamp_geometry(regs[vgat_pkg::CFG_COLS]);
        SEQ_HFRONT: return min_one(regs[vgat_pkg::CFG_HFRONT]);
        default:    return min_one(regs[vgat_pkg::CFG_VFRONT]);
      endcase
    endfunction

    function void note_item(vgat_pkg::in_t d);
      vgat_pkg::out_t r;
      n_items++;
      if (d.func == vgat_pkg::FUNC_WRITE) begin
        n_writes++;
        if (pixel_q.size() < vgat_pkg::FIFO_DEPTH_DEF) begin
          pixel_q.push_back(d.wr_pixel);
        end else begin
          n_dropped++;
        end
        return;
      end
      r = '0;
      if (ticks_left == 0) begin
        ticks_left = phase_ticks();
        if (seq == SEQ_VSYNC) line_no = 0;
      end
      case (seq)
        SEQ_VSYNC: begin
          vs_level = 1'b0;
          hs_level = 1'b1;
        end
        SEQ_VBACK, SEQ_VFRONT: vs_level = 1'b1;
        SEQ_HSYNC: hs_level = 1'b0;
        SEQ_ACTIVE: begin
          hs_level = 1'b1;
          r.pixel_strobe = 1'b1;
          if (pixel_q.size() > 0) r.pixel_value = pixel_q.pop_front();
        end
        default: hs_level = 1'b1;
      endcase
      ticks_left--;
      if (ticks_left == 0) begin
        case (seq)
          SEQ_VSYNC:  seq = SEQ_VBACK;
          SEQ_VBACK:  seq = SEQ_HSYNC;
          SEQ_HSYNC:  seq = SEQ_HBACK;
          SEQ_HBACK:  seq = SEQ_ACTIVE;
          SEQ_ACTIVE: seq = SEQ_HFRONT;
          SEQ_HFRONT: begin
            if (line_no + 1 >= clamp_geometry(regs[vgat_pkg::CFG_ROWS])) begin
              seq = SEQ_VFRONT;
            end else begin
              seq = SEQ_HSYNC;
            end
            line_no = (line_no + 1) & 'h7FF;
          end
          default: seq = SEQ_VSYNC;
        endcase
      end
      r.hsync_n = hs_level;
      r.vsync_n = vs_level;
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      errors++;
      if (errors <= 20) begin
        $display("mismatch on %s at result %0d: got %0h, want %0h", what, n_results, got, want);
      end
    endtask

    task check_result(vgat_pkg::out_t got);
      vgat_pkg::out_t want;
      n_results++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 32'(got), 0);
        return;
      end
      want = expected_q.pop_front();
      if (got.hsync_n !== want.hsync_n) begin
        report_mismatch("hsync_n", 32'(got.hsync_n), 32'(want.hsync_n));
      end
      if (got.vsync_n !== want.vsync_n) begin
        report_mismatch("vsync_n", 32'(got.vsync_n), 32'(want.vsync_n));
      end
      if (got.pixel_strobe !== want.pixel_strobe) begin
        report_mismatch("pixel_strobe", 32'(got.pixel_strobe), 32'(want.pixel_strobe));
      end
      if (got.pixel_value !== want.pixel_value) begin
        report_mismatch("pixel_value", 32'(got.pixel_value), 32'(want.pixel_value));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  vgat_pkg::in_t                   in_data;
  logic                            out_valid;
  logic                            out_ready;
  vgat_pkg::out_t                  out_data;
  logic                            cfg_we;
  vgat_pkg::cfg_idx_t              cfg_index;
  logic [vgat_pkg::CFG_DATA_W-1:0] cfg_data;

  bit in_steady;
  bit out_steady;

  frame_scoreboard sb = new();

  vga_timing_with_pixel_fifo i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("vga_timing_with_pixel_fifo regression: fail");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75) return 0;
    if (r < 96) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [vgat_pkg::CFG_DATA_W-1:0] pick_cfg(int unsigned lo, int unsigned hi);
    return vgat_pkg::CFG_DATA_W'($urandom_range(hi, lo));
  endfunction

  initial begin
    int unsigned stall;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (out_steady) begin
        out_ready <= 1'b1;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          stall--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  task automatic load_timing(input logic [15:0] vs, vb, vf, hs, hb, hf, cols, rows);
    logic [15:0] vals [8];
    vals = '{vs, vb, vf, hs, hb, hf, cols, rows};
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= vgat_pkg::cfg_idx_t'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.write_reg(vgat_pkg::cfg_idx_t'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(vgat_pkg::in_t d);
    int unsigned gap;
    gap = in_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(d);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_burst(int unsigned n, int unsigned write_pct);
    vgat_pkg::in_t d;
    for (int unsigned i = 0; i < n; i++) begin
      d.func     = ($urandom_range(99) < write_pct) ? vgat_pkg::FUNC_WRITE : vgat_pkg::FUNC_TICK;
      d.wr_pixel = vgat_pkg::PIX_W'($urandom);
      send_item(d);
    end
  endtask

  initial begin
    int unsigned write_pct;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= vgat_pkg::CFG_VSYNC;
    cfg_data  <= '0;
    in_steady  = 1'b0;
    out_steady = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // two vsync ticks at reset timing, then every phase once with an underrun
    send_item('{func: vgat_pkg::FUNC_WRITE, wr_pixel: 12'hFFF});
    send_item('{func: vgat_pkg::FUNC_WRITE, wr_pixel: 12'h000});
    send_item('{func: vgat_pkg::FUNC_WRITE, wr_pixel: 12'hAAA});
    send_item('{func: vgat_pkg::FUNC_WRITE, wr_pixel: 12'h555});
    repeat (2) send_item('{func: vgat_pkg::FUNC_TICK, wr_pixel: 12'h000});
    settle();
    load_timing(16'd0, 16'd1, 16'd0, 16'd1, 16'd0, 16'd1, 16'd6, 16'd0);
    repeat (12) send_item('{func: vgat_pkg::FUNC_TICK, wr_pixel: 12'hFFF});
    settle();

    for (int k = 0; k < 8; k++) begin
      in_steady  = (k == 1 || k == 4);
      out_steady = (k == 2 || k == 5);
      case (k)
        0: begin
          load_timing(pick_cfg(1, 3), pick_cfg(1, 3), pick_cfg(1, 3),
                      pick_cfg(1, 3), pick_cfg(1, 3), pick_cfg(1, 3),
                      pick_cfg(1, 8), pick_cfg(1, 4));
          write_pct = 50;
        end
        1: begin
          load_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
          write_pct = 60;
        end
        2: begin
          load_timing(pick_cfg(1, 4), pick_cfg(1, 4), pick_cfg(1, 4),
                      pick_cfg(1, 4), pick_cfg(1, 4), pick_cfg(1, 4),
                      pick_cfg(1, 6), pick_cfg(1, 3));
          write_pct = 90;
        end
        3: begin
          load_timing(pick_cfg(1, 2), pick_cfg(1, 2), pick_cfg(1, 2),
                      pick_cfg(1, 2), pick_cfg(1, 2), pick_cfg(1, 2),
                      pick_cfg(4, 12), pick_cfg(1, 3));
          write_pct = 15;
        end
        4: begin
          load_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd64, 16'd3);
          write_pct = 50;
        end
        5: begin
          load_timing(pick_cfg(1, 9), pick_cfg(1, 9), pick_cfg(1, 9),
                      pick_cfg(1, 9), pick_cfg(1, 9), pick_cfg(1, 9),
                      pick_cfg(1, 20), pick_cfg(1, 5));
          write_pct = 50;
        end
        6: begin
          load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'hFFFF, 16'hFFFF);
          write_pct = 40;
        end
        default: begin
          load_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0800, 16'h0800);
          write_pct = 40;
        end
      endcase
      random_burst(180, write_pct);
      settle();
    end

    repeat (10) @(posedge clk);
    $display("covered %0d items: %0d pixel writes (%0d dropped on a full queue), %0d results",
             sb.n_items, sb.n_writes, sb.n_dropped, sb.n_results);
    $display("across reset timing and nine register settings, zero and maximum values included");
    if (sb.errors == 0) begin
      $display("vga_timing_with_pixel_fifo regression: pass");
    end else begin
      $display("vga_timing_with_pixel_fifo regression: fail");
    end
    $finish;
  end

endmodule
